[design/phonebook_app_param_tlv_parser_assert.svh]
// Assertion macros used by the checker file of the parser.
`ifndef PHONEBOOK_APP_PARAM_TLV_PARSER_ASSERT_SVH
`define PHONEBOOK_APP_PARAM_TLV_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PBTLV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pbtlv assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PBTLV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pbtlv assertion failed");

`endif

[design/pbtlv_pkg.sv]
`timescale 1ns / 1ps
package pbtlv_pkg;

    typedef enum logic [1:0] {
        PH_TAG = 2'd0,
        PH_LEN = 2'd1,
        PH_VAL = 2'd2
    } t_phase;

    localparam logic [7:0] TAG_ORDER   = 8'h01;
    localparam logic [7:0] TAG_SVALUE  = 8'h02;
    localparam logic [7:0] TAG_SATTR   = 8'h03;
    localparam logic [7:0] TAG_MAXCNT  = 8'h04;
    localparam logic [7:0] TAG_OFFSET  = 8'h05;
    localparam logic [7:0] TAG_PROPSEL = 8'h06;
    localparam logic [7:0] TAG_FORMAT  = 8'h07;
    localparam logic [7:0] TAG_CARDSEL = 8'h0C;
    localparam logic [7:0] TAG_SELOP   = 8'h0E;
    localparam logic [7:0] TAG_FEAT    = 8'h10;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        parse_ok;
        logic [63:0] property_selector;
        logic        ignore_filter;
        logic [31:0] supported_features;
        logic [7:0]  sort_order;
        logic [7:0]  search_attribute;
        logic [15:0] max_list_count;
        logic        need_size;
        logic [15:0] list_start_offset;
        logic [7:0]  card_format;
        logic [63:0] card_selector;
        logic [7:0]  selector_operator;
    } t_out_item;

    // Handshake between the input register and the parse core.
    typedef struct packed {
        logic valid;
        logic take;
    } t_in_ctl;

    function automatic logic tag_known(input logic [7:0] t);
        logic k;
        unique case (t) inside
            TAG_ORDER, TAG_SVALUE, TAG_SATTR, TAG_MAXCNT, TAG_OFFSET,
            TAG_PROPSEL, TAG_FORMAT, TAG_CARDSEL, TAG_SELOP, TAG_FEAT: k = 1'b1;
            default: k = 1'b0;
        endcase
        return k;
    endfunction

    // Fixed value size in bytes; zero for the variable-length search value and unknown tags.
    function automatic logic [3:0] tag_size(input logic [7:0] t);
        logic [3:0] s;
        unique case (t) inside
            TAG_ORDER, TAG_SATTR, TAG_FORMAT, TAG_SELOP: s = 4'd1;
            TAG_MAXCNT, TAG_OFFSET:                      s = 4'd2;
            TAG_FEAT:                                    s = 4'd4;
            TAG_PROPSEL, TAG_CARDSEL:                    s = 4'd8;
            default:                                     s = 4'd0;
        endcase
        return s;
    endfunction

endpackage

[design/phonebook_app_param_tlv_parser.sv]
// A byte is registered at acceptance and processed by the core from that register;
// the result of a block is loaded into the output register when its last byte is taken.
// Throughput: one byte per cycle while the input is not stalled, set by the parse state update.
// The input stalls only when a finished result is still held by the output.
// Reset (synchronous, active low) empties both registers and restarts parsing.
`timescale 1ns / 1ps
module phonebook_app_param_tlv_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  pbtlv_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output pbtlv_pkg::t_out_item o_out_item
);
    import pbtlv_pkg::*;

    t_in_ctl   in_ctl;
    t_in_item  held_item;
    t_out_item result;
    logic      take;
    logic      fire;
    logic      load;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out_item;

    // A held last byte waits while the previous result is still unread.
    assign take = !(held_item.last_byte && r_out_valid && i_out_stall);
    assign fire = in_ctl.take;
    assign load = fire && held_item.last_byte;

    pbtlv_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_item (i_in_item),
        .i_take    (take),
        .o_stall   (o_in_stall),
        .o_ctl     (in_ctl),
        .o_item    (held_item)
    );

    pbtlv_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (held_item),
        .o_result(result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
endmodule

[design/pbtlv_in_reg.sv]
`timescale 1ns / 1ps
module pbtlv_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  pbtlv_pkg::t_in_item i_in_item,
    input  logic                i_take,
    output logic                o_stall,
    output pbtlv_pkg::t_in_ctl  o_ctl,
    output pbtlv_pkg::t_in_item o_item
);
    import pbtlv_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     accept;

    // A held byte blocks the input only while the core cannot take it.
    assign o_stall = r_valid && !i_take;
    assign accept  = i_in_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (r_valid && i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_item;
        end
    end

    assign o_ctl.valid = r_valid;
    assign o_ctl.take  = r_valid && i_take;
    assign o_item      = r_item;
endmodule

[design/pbtlv_core.sv]
`timescale 1ns / 1ps
module pbtlv_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  pbtlv_pkg::t_in_item  i_item,
    output pbtlv_pkg::t_out_item o_result
);
    import pbtlv_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [7:0]  r_tag,    n_tag;
    logic [7:0]  r_left,   n_left;
    logic        r_failed, n_failed;
    logic [63:0] r_accum,  n_accum;
    logic [63:0] r_sel,    n_sel;
    logic        r_ignore, n_ignore;
    logic [31:0] r_feat,   n_feat;
    logic [7:0]  r_order,  n_order;
    logic [7:0]  r_sattr,  n_sattr;
    logic [7:0]  r_format, n_format;
    logic [7:0]  r_selop,  n_selop;
    logic [15:0] r_count,  n_count;
    logic        r_need,   n_need;
    logic [15:0] r_offset, n_offset;
    logic [63:0] r_csel,   n_csel;
    logic [7:0]  left_dec;
    logic [3:0]  size;

    always_comb begin
        n_phase  = r_phase;
        n_tag    = r_tag;
        n_left   = r_left;
        n_failed = r_failed;
        n_accum  = r_accum;
        n_sel    = r_sel;
        n_ignore = r_ignore;
        n_feat   = r_feat;
        n_order  = r_order;
        n_sattr  = r_sattr;
        n_format = r_format;
        n_selop  = r_selop;
        n_count  = r_count;
        n_need   = r_need;
        n_offset = r_offset;
        n_csel   = r_csel;
        size     = tag_size(r_tag);
        left_dec = (r_left != 8'd0) ? r_left - 8'd1 : 8'd0;

        if (!r_failed) begin
            unique case (r_phase)
                PH_TAG: begin
                    if (!tag_known(i_item.data_byte)) begin
                        n_failed = 1'b1;
                    end else begin
                        n_tag   = i_item.data_byte;
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    // Fixed-size tags ignore the length byte.
                    if (size == 4'd0) begin
                        if (i_item.data_byte == 8'd0) begin
                            n_failed = 1'b1;
                        end else begin
                            n_left  = i_item.data_byte;
                            n_accum = '0;
                            n_phase = PH_VAL;
                        end
                    end else begin
                        n_left  = {4'd0, size};
                        n_accum = '0;
                        n_phase = PH_VAL;
                    end
                end
                PH_VAL: begin
                    n_accum = {r_accum[55:0], i_item.data_byte};
                    n_left  = left_dec;
                    if (left_dec == 8'd0) begin
                        n_phase = PH_TAG;
                        case (r_tag)
                            TAG_ORDER:  n_order  = n_accum[7:0];
                            TAG_SATTR:  n_sattr  = n_accum[7:0];
                            TAG_FORMAT: n_format = n_accum[7:0];
                            TAG_SELOP:  n_selop  = n_accum[7:0];
                            TAG_MAXCNT: begin
                                if (n_accum[15:0] == 16'd0) begin
                                    n_need = 1'b1;
                                end else begin
                                    n_count = n_accum[15:0];
                                end
                            end
                            TAG_OFFSET: n_offset = n_accum[15:0];
                            TAG_FEAT:   n_feat   = n_accum[31:0];
                            TAG_PROPSEL: begin
                                n_sel = n_accum;
                                if (n_accum != 64'd0) begin
                                    n_ignore = 1'b0;
                                end
                            end
                            TAG_CARDSEL: n_csel = n_accum;
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end

        o_result.parse_ok           = !n_failed && (n_phase == PH_TAG);
        o_result.property_selector  = n_sel;
        o_result.ignore_filter      = n_ignore;
        o_result.supported_features = n_feat;
        o_result.sort_order         = n_order;
        o_result.search_attribute   = n_sattr;
        o_result.max_list_count     = n_count;
        o_result.need_size          = n_need;
        o_result.list_start_offset  = n_offset;
        o_result.card_format        = n_format;
        o_result.card_selector      = n_csel;
        o_result.selector_operator  = n_selop;
    end

    // The last byte of a block returns every register to its start value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_item.last_byte)) begin
            r_phase  <= PH_TAG;
            r_tag    <= 8'd0;
            r_left   <= 8'd0;
            r_failed <= 1'b0;
            r_accum  <= 64'd0;
            r_sel    <= 64'd0;
            r_ignore <= 1'b1;
            r_feat   <= 32'd0;
            r_order  <= 8'd0;
            r_sattr  <= 8'd0;
            r_format <= 8'd0;
            r_selop  <= 8'd0;
            r_count  <= 16'hFFFF;
            r_need   <= 1'b0;
            r_offset <= 16'd0;
            r_csel   <= 64'd0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_tag    <= n_tag;
            r_left   <= n_left;
            r_failed <= n_failed;
            r_accum  <= n_accum;
            r_sel    <= n_sel;
            r_ignore <= n_ignore;
            r_feat   <= n_feat;
            r_order  <= n_order;
            r_sattr  <= n_sattr;
            r_format <= n_format;
            r_selop  <= n_selop;
            r_count  <= n_count;
            r_need   <= n_need;
            r_offset <= n_offset;
            r_csel   <= n_csel;
        end
    end
endmodule

[design/pbtlv_chk.sv]
`timescale 1ns / 1ps
`include "phonebook_app_param_tlv_parser_assert.svh"
module pbtlv_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input pbtlv_pkg::t_in_item  i_in_item,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input pbtlv_pkg::t_out_item o_out_item
);
    import pbtlv_pkg::*;

    // The input is only ever held up by an unread result.
    `PBTLV_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

    // No result is shown in the first cycle after reset.
    `PBTLV_ASSERT_NOW(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !o_out_valid)

    `PBTLV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    `PBTLV_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_item))
endmodule

bind phonebook_app_param_tlv_parser pbtlv_chk u_pbtlv_chk (.*);
